>>> sv/lcg_rrg_pkg.sv
// Package for the LCG random range generator: command codes, controller
// states and the command/status bundles between controller and datapath.
// No dependencies.
package lcg_rrg_pkg;

  localparam logic [2:0] CMD_RAW    = 3'd0;
  localparam logic [2:0] CMD_SIGNED = 3'd1;
  localparam logic [2:0] CMD_RANGE  = 3'd2;
  localparam logic [2:0] CMD_MIN2   = 3'd3;
  localparam logic [2:0] CMD_SEED   = 3'd4;

  localparam logic [31:0] LCG_MUL   = 32'd1103515245;
  localparam logic [31:0] LCG_INC   = 32'd12345;
  localparam logic [15:0] DRAW_MAX  = 16'hffff;
  localparam logic [16:0] FOLD_BASE = 17'h07fff;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_BOUND_GO,
    S_BOUND,
    S_CHECK,
    S_MOD,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic load;        // capture a new word from the input channel
    logic advance;     // step the generator state
    logic div_start;   // launch the remainder unit
    logic div_draw;    // dividend is the current draw, else 0xffff
    logic bound_load;  // capture the rejection bound
    logic first_load;  // hold the first of two range draws
    logic out_load;    // place the result in the output register
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       div_done;
    logic       draw_ok;
    logic       out_free;
  } sts_t;

endpackage

>>> sv/lcg_rrg_if.sv
// Channel interfaces for the LCG random range generator.
// Depends on nothing; one interface for requests, one for results.
interface lcg_rrg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [14:0] range_limit;
  logic [31:0] seed_value;

  modport source (output valid, output cmd, output range_limit, output seed_value,
                  input ready);
  modport sink (input valid, input cmd, input range_limit, input seed_value,
                output ready);
endinterface

interface lcg_rrg_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

>>> sv/lcg_rrg_rem.sv
// Restoring remainder unit, one quotient bit per cycle.
// Used by the datapath for the rejection bound and the final modulo.
module lcg_rrg_rem (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [14:0] rem
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [14:0] rem_r, rem_nxt;
  logic [15:0] dvd_r, dvd_nxt;
  logic [15:0] trial;
  logic        fits;

  // partial remainder stays below the divisor (at most 32768), so 15 bits hold it
  assign trial = {rem_r, dvd_r[15]};
  assign fits  = (trial >= divisor);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? 15'(trial - divisor) : trial[14:0];
      dvd_nxt = {dvd_r[14:0], 1'b0};
      cnt_nxt = 4'(cnt_r + 4'd1);
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> sv/lcg_rrg_dp.sv
// Datapath: generator state, rejection bound, first draw, output register.
// Depends on lcg_rrg_pkg and lcg_rrg_rem.
module lcg_rrg_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  lcg_rrg_pkg::ctl_t   ctl,
  output lcg_rrg_pkg::sts_t   sts,
  input  logic [2:0]          in_cmd,
  input  logic [14:0]         in_range_limit,
  input  logic [31:0]         in_seed_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [16:0]  out_value
);
  import lcg_rrg_pkg::*;

  logic [2:0]         cmd_r;
  logic [14:0]        limit_r;
  logic [31:0]        lcg_r, lcg_nxt;
  logic [15:0]        bound_r;
  logic [14:0]        first_r;
  logic               out_valid_r, out_valid_nxt;
  logic signed [16:0] out_value_r;
  logic [16:0]        result;
  logic [15:0]        draw;
  logic [15:0]        span;
  logic [15:0]        dividend;
  logic               div_done;
  logic [14:0]        rem;
  logic [14:0]        smaller;
  logic               out_free;

  assign draw     = lcg_r[23:8];
  assign span     = 16'({1'b0, limit_r} + 16'd1);
  assign dividend = ctl.div_draw ? draw : DRAW_MAX;
  assign smaller  = (first_r < rem) ? first_r : rem;
  assign out_free = !out_valid_r || out_ready;

  lcg_rrg_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (dividend),
    .divisor  (span),
    .done     (div_done),
    .rem      (rem)
  );

  always_comb begin
    lcg_nxt = lcg_r;
    if (ctl.load && (in_cmd == CMD_SEED)) begin
      lcg_nxt = in_seed_value;
    end else if (ctl.advance) begin
      lcg_nxt = 32'(lcg_r * LCG_MUL + LCG_INC);
    end
  end

  always_comb begin
    case (cmd_r)
      CMD_RAW:    result = {1'b0, draw};
      // fold draws above 0x7fff onto the negatives
      CMD_SIGNED: result = draw[15] ? 17'(FOLD_BASE - {1'b0, draw}) : {1'b0, draw};
      CMD_RANGE:  result = {2'b00, rem};
      CMD_MIN2:   result = {2'b00, smaller};
      default:    result = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lcg_r       <= lcg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (ctl.load) begin
      cmd_r   <= in_cmd;
      limit_r <= in_range_limit;
    end
    if (ctl.bound_load) begin
      bound_r <= 16'(DRAW_MAX - {1'b0, rem});
    end
    if (ctl.first_load) begin
      first_r <= rem;
    end
    if (ctl.out_load) begin
      out_value_r <= $signed(result);
    end
  end

  always_comb begin
    sts.cmd      = cmd_r;
    sts.div_done = div_done;
    sts.draw_ok  = (draw < bound_r);
    sts.out_free = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  a_bound_large: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.bound_load |=> bound_r >= 16'h8000)
    else $error("rejection bound below half range");

  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.bound_load |-> {1'b0, rem} < span)
    else $error("remainder not below divisor");

  a_seed_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load && (in_cmd == CMD_SEED) |=> lcg_r == $past(in_seed_value))
    else $error("seed not loaded");

endmodule

>>> sv/lcg_rrg_ctrl.sv
// Controller state machine: sequences draws, rejection and remainder runs.
// Depends on lcg_rrg_pkg; drives the datapath through ctl_t.
module lcg_rrg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2:0]        in_cmd,
  output logic              in_ready,
  input  lcg_rrg_pkg::sts_t sts,
  output lcg_rrg_pkg::ctl_t ctl
);
  import lcg_rrg_pkg::*;

  state_t state_r, state_nxt;
  logic   second_r, second_nxt;
  logic   need_second;

  assign need_second = (sts.cmd == CMD_MIN2) && !second_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_RAW, CMD_SIGNED: state_nxt = S_ADV;
            CMD_RANGE, CMD_MIN2: state_nxt = S_BOUND_GO;
            default:             state_nxt = S_RESULT;
          endcase
        end
      end
      S_ADV:      state_nxt = S_RESULT;
      S_BOUND_GO: state_nxt = S_BOUND;
      S_BOUND: begin
        if (sts.div_done) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.draw_ok) state_nxt = S_MOD;
      end
      S_MOD: begin
        if (sts.div_done) state_nxt = need_second ? S_CHECK : S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    in_ready   = 1'b0;
    second_nxt = second_r;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        ctl.load   = in_valid;
        second_nxt = 1'b0;
      end
      S_ADV: ctl.advance = 1'b1;
      S_BOUND_GO: ctl.div_start = 1'b1;
      S_BOUND: begin
        // bound ready: take it and make the first draw
        ctl.bound_load = sts.div_done;
        ctl.advance    = sts.div_done;
      end
      S_CHECK: begin
        // accept the draw and reduce it, or drop it and draw again
        ctl.div_start = sts.draw_ok;
        ctl.div_draw  = sts.draw_ok;
        ctl.advance   = !sts.draw_ok;
      end
      S_MOD: begin
        if (sts.div_done && need_second) begin
          ctl.first_load = 1'b1;
          ctl.advance    = 1'b1;
          second_nxt     = 1'b1;
        end
      end
      S_RESULT: ctl.out_load = sts.out_free;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> sts.out_free)
    else $error("result loaded over a pending word");

  a_no_adv_with_div: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.div_start |-> !ctl.advance && !ctl.load)
    else $error("state stepped while remainder unit launched");

  a_check_to_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) && sts.draw_ok |=> (state_r == S_MOD) && !sts.div_done)
    else $error("accepted draw did not start reduction");

endmodule

>>> sv/lcg_random_range_generator.sv
// LCG random range generator: a 32-bit ANSI C style recurrence with raw,
// signed, uniform-in-range and min-of-two draws and a seed load. One request
// word is taken at a time and gives one result word. Raw and signed draws step
// the generator once before the result is loaded; a seed goes straight to the
// result. A range request makes k draws (usually 1 for small ranges, and the
// expected number is at most 2); min-of-two makes two such range draws that
// share one rejection bound. The time is set by the bit-serial remainder unit,
// run once for the rejection bound and once per accepted draw, and by one
// generator step per cycle while draws are rejected. A new request is taken
// while the previous result still waits in the output register.
module lcg_random_range_generator (
  input  logic              clk,
  input  logic              rst_n,
  lcg_rrg_in_if.sink        in_ch,
  lcg_rrg_out_if.source     out_ch
);
  import lcg_rrg_pkg::*;

  ctl_t ctl;
  sts_t sts;

  lcg_rrg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  lcg_rrg_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_cmd         (in_ch.cmd),
    .in_range_limit (in_ch.range_limit),
    .in_seed_value  (in_ch.seed_value),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_value      (out_ch.value)
  );

endmodule

>>> test/tb.sv
// Self-checking bench for lcg_random_range_generator: a directed table, then
// random request words checked against an in-bench generator model.
// Depends on lcg_rrg_pkg, the channel interfaces and the top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcg_rrg_pkg::*;

  // reserved command codes: the block leaves its state alone and returns a zero result word
  localparam logic [2:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [2:0] CMD_RSVD_MID = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI  = 3'd7;

  localparam int RAND_PER_PHASE = 500;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 100;
  localparam int LIMIT_CYCLES   = 1000000;
  localparam int MAX_REPORTS    = 200;

  typedef struct {
    logic [2:0]         cmd;
    logic [14:0]        lim;
    logic [31:0]        seed;
    bit                 known;
    logic signed [16:0] value;
  } req_t;

  logic clk = 1'b0;
  logic rst_n;

  lcg_rrg_in_if  in_ch ();
  lcg_rrg_out_if out_ch ();

  lcg_random_range_generator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  logic [31:0]        gen_state;
  logic signed [16:0] pending_values[$];
  int                 err_cnt = 0;
  int                 cycle_cnt = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 hold_req = 0;

  // ---------------------------------------------------------------- model
  function automatic logic [15:0] next_draw();
    gen_state = gen_state * LCG_MUL + LCG_INC;
    return gen_state[23:8];
  endfunction

  function automatic logic [15:0] ranged_draw(logic [14:0] lim);
    int unsigned span, bound, d;
    span  = lim + 1;
    bound = (DRAW_MAX / span) * span;
    d = 32'(next_draw());
    while (d >= bound) d = 32'(next_draw());
    return 16'(d % span);
  endfunction

  function automatic logic signed [16:0] predict_word(logic [2:0] cmd, logic [14:0] lim,
                                                      logic [31:0] seed);
    logic [15:0] d, a, b;
    predict_word = '0;
    case (cmd)
      CMD_RAW: predict_word = {1'b0, next_draw()};
      CMD_SIGNED: begin
        d = next_draw();
        // fold the upper half onto -32768..-1
        predict_word = (d > 16'h7fff) ? FOLD_BASE - {1'b0, d} : {1'b0, d};
      end
      CMD_RANGE: predict_word = {1'b0, ranged_draw(lim)};
      CMD_MIN2: begin
        a = ranged_draw(lim);
        b = ranged_draw(lim);
        predict_word = {1'b0, (a < b) ? a : b};
      end
      CMD_SEED: gen_state = seed;
      default: ;
    endcase
  endfunction

  // state whose next step lands on a chosen draw, via the inverse multiplier
  function automatic logic [31:0] seed_for_draw(logic [15:0] d);
    logic [31:0] inv;
    inv = LCG_MUL;
    repeat (5) inv = inv * (32'd2 - LCG_MUL * inv);
    return ({8'h00, d, 8'h00} - LCG_INC) * inv;
  endfunction

  // ------------------------------------------------------------- stimulus
  function automatic req_t row(logic [2:0] cmd, logic [14:0] lim, logic [31:0] seed,
                               bit known, logic signed [16:0] value);
    req_t r;
    r.cmd = cmd; r.lim = lim; r.seed = seed; r.known = known; r.value = value;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    r.known = 1'b0;
    r.value = '0;
    r.seed  = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 8)       r.cmd = CMD_SEED;
    else if (pick < 11) r.cmd = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    else if (pick < 23) r.cmd = CMD_RAW;
    else if (pick < 35) r.cmd = CMD_SIGNED;
    else if (pick < 70) r.cmd = CMD_RANGE;
    else                r.cmd = CMD_MIN2;
    case ($urandom_range(0, 9))
      0:       r.lim = '0;
      1:       r.lim = '1;
      2:       r.lim = 15'((32'd1 << $urandom_range(0, 15)) - 1);
      3, 4, 5: r.lim = 15'($urandom_range(0, 15));
      default: r.lim = 15'($urandom_range(0, 32767));
    endcase
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic offer_word(req_t r);
    logic signed [16:0] v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid       = 1'b0;
      in_ch.cmd         = 3'($urandom);
      in_ch.range_limit = 15'($urandom);
      in_ch.seed_value  = $urandom;
      @(negedge clk);
    end
    in_ch.cmd         = r.cmd;
    in_ch.range_limit = r.lim;
    in_ch.seed_value  = r.seed;
    in_ch.valid       = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    v = predict_word(r.cmd, r.lim, r.seed);
    pending_values.push_back(r.known ? r.value : v);
    @(negedge clk);
  endtask

  // ------------------------------------------------------------- receiver
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // -------------------------------------------------------------- checker
  always @(posedge clk) begin
    logic signed [16:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_values.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $error("unexpected result word: value %0d", out_ch.value);
      end else begin
        want = pending_values.pop_front();
        if (out_ch.value !== want) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $error("value: expected %0d, got %0d", want, out_ch.value);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: errors");
    $finish;
  end

  // ----------------------------------------------------------------- main
  initial begin
    req_t directed[$];
    gen_state         = '0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_RAW;
    in_ch.range_limit = '0;
    in_ch.seed_value  = '0;

    directed.push_back(row(CMD_RAW,    '0, '0, 1, 48));  // first draw from zero state
    directed.push_back(row(CMD_SIGNED, '0, '0, 0, 0));
    directed.push_back(row(CMD_SEED,   '0, '1, 1, 0));
    directed.push_back(row(CMD_RAW,    '1, '0, 0, 0));
    directed.push_back(row(CMD_SEED,   '0, seed_for_draw(16'h0000), 1, 0));
    directed.push_back(row(CMD_RAW,    '0, '0, 1, 0));
    directed.push_back(row(CMD_SEED,   '0, seed_for_draw(16'hffff), 1, 0));
    directed.push_back(row(CMD_RAW,    '0, '0, 1, 65535));
    directed.push_back(row(CMD_SEED,   '0, seed_for_draw(16'hffff), 1, 0));
    directed.push_back(row(CMD_SIGNED, '0, '0, 1, -32768));
    directed.push_back(row(CMD_SEED,   '0, seed_for_draw(16'h8000), 1, 0));
    directed.push_back(row(CMD_SIGNED, '0, '0, 1, -1));
    directed.push_back(row(CMD_SEED,   '0, seed_for_draw(16'h7fff), 1, 0));
    directed.push_back(row(CMD_SIGNED, '0, '0, 1, 32767));
    // zero range straight after a 0xffff draw: the draw is rejected, result is 0
    directed.push_back(row(CMD_SEED,   '0, seed_for_draw(16'hffff), 1, 0));
    directed.push_back(row(CMD_RANGE,  '0, '0, 1, 0));
    directed.push_back(row(CMD_MIN2,   '0, '0, 1, 0));
    directed.push_back(row(CMD_RANGE,  '1, '0, 0, 0));
    directed.push_back(row(CMD_MIN2,   '1, '0, 0, 0));
    directed.push_back(row(CMD_RANGE,  15'd1, '0, 0, 0));
    directed.push_back(row(CMD_MIN2,   15'd12345, '0, 0, 0));
    directed.push_back(row(CMD_RSVD_LO,  '1, '1, 1, 0));
    directed.push_back(row(CMD_RSVD_MID, '1, '1, 1, 0));
    directed.push_back(row(CMD_RSVD_HI,  '0, '0, 1, 0));
    directed.push_back(row(CMD_SEED,   '0, '0, 1, 0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) offer_word(directed[i]);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 37; recv_idle_pct = 78; end
        1: begin send_idle_pct = 78; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // stall the result side for a while so the block backs up into its input
      if (p == 2) hold_req++;
      repeat (RAND_PER_PHASE) offer_word(random_request());
      // drop valid and wait for every outstanding result
      in_ch.valid = 1'b0;
      while (pending_values.size() != 0) @(posedge clk);
      @(negedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

>>> filelist.f
sv/lcg_rrg_pkg.sv
sv/lcg_rrg_if.sv
sv/lcg_rrg_rem.sv
sv/lcg_rrg_dp.sv
sv/lcg_rrg_ctrl.sv
sv/lcg_random_range_generator.sv
test/tb.sv
